// ===== hw/rtl/pts_pkg.sv =====
// ---------------------------------------------------------------------------
// Priority thread scheduler package
// Shared constants, command and status codes, the cell-to-cell search word type and the command type.
// ---------------------------------------------------------------------------
package pts_pkg;

  localparam int MaxThreads = 8;
  localparam int SlotW      = (MaxThreads > 1) ? $clog2(MaxThreads) : 1;
  localparam int CntW       = $clog2(MaxThreads + 1);

  localparam logic [2:0] K_CREATE    = 3'd0;
  localparam logic [2:0] K_TERMINATE = 3'd1;
  localparam logic [2:0] K_SUSPEND   = 3'd2;
  localparam logic [2:0] K_RESUME    = 3'd3;
  localparam logic [2:0] K_TICK      = 3'd4;
  localparam logic [2:0] K_SCHEDULE  = 3'd5;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_SWITCHED = 3'd1;
  localparam logic [2:0] ST_NOSWITCH = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Search word handed down the chain of cells, one cell a cycle
  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] slot;
    logic [15:0]      ident;
    logic [7:0]       prio;
  } pts_search_t;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic        tick;      // count down the nonzero countdowns of valid entries
    logic        create;    // write entry at wr_slot
    logic        kill;      // free entry at wr_slot
    logic        susp_wr;   // write suspended bit at wr_slot
    logic        susp_val;
    logic        reload;    // reload countdown at wr_slot
    logic [SlotW-1:0] wr_slot;
    logic [15:0] ident;
    logic [7:0]  prio;
  } pts_cmd_t;

endpackage

// ===== hw/rtl/priority_thread_scheduler_core.sv =====
// ---------------------------------------------------------------------------
// Priority thread scheduler core
// Thread table as a chain of cells, scanned one cell per cycle by a sequencer.
// ---------------------------------------------------------------------------
// Create, terminate, suspend, resume and schedule strobe done once the scan has stepped
// the search word through every cell, one cell a cycle; tick goes straight to finish.
// One command at a time: busy holds from acceptance until the sequencer is idle again,
// so no new command is taken while one is in flight.
// Results are strobed for one cycle on done; the receiver cannot stall.
// Reset (rst, synchronous) empties the table and clears current and last id.
module priority_thread_scheduler_core import pts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [7:0]  priority_req,
  input  logic [15:0] target_id,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] result_id,
  output logic [7:0]  result_priority
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t          state;
  logic [2:0]      op;
  logic [7:0]      op_prio;
  logic [15:0]     op_id;
  logic [CntW-1:0] idx;
  logic [SlotW-1:0] cur_slot;
  logic            cur_valid;
  logic [15:0]     last_id;
  pts_cmd_t        cmd;
  pts_search_t     head;
  pts_search_t     chain [MaxThreads+1];
  logic [MaxThreads-1:0] valid_vec;
  logic [15:0]     new_id;

  assign head     = '0;
  assign chain[0] = head;
  assign new_id   = last_id + 16'd1;

  // Row of cells; the search word moves one cell each scan cycle
  for (genvar g = 0; g < MaxThreads; g++) begin : g_cell
    pts_cell u_cell (
      .clk(clk), .rst(rst), .my_slot(SlotW'(g)), .mode(op), .key_id(op_id),
      .srch_in(chain[g]), .step(state == S_SCAN && idx == CntW'(g)),
      .srch_out(chain[g+1]), .cmd(cmd), .valid(valid_vec[g])
    );
  end

  assign busy = (state != S_IDLE);

  // Sequencer, table updates and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      cmd       <= '0;
      cur_valid <= 1'b0;
      cur_slot  <= '0;
      last_id   <= '0;
      idx       <= '0;
    end else begin
      done <= 1'b0;
      cmd  <= '0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op      <= kind;
            op_prio <= priority_req;
            op_id   <= target_id;
            idx     <= '0;
            if (kind == K_TICK) begin
              cmd.tick <= 1'b1;
              state    <= S_FINISH;
            end else if (kind inside {K_CREATE, K_TERMINATE, K_SUSPEND, K_RESUME,
                                      K_SCHEDULE}) begin
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          idx <= idx + CntW'(1);
          if (idx == CntW'(MaxThreads)) begin
            state           <= S_FINISH;
            done            <= 1'b1;
            status          <= ST_DONE;
            result_id       <= '0;
            result_priority <= '0;
            cmd.wr_slot     <= chain[MaxThreads].slot;
            case (op)
              K_CREATE: begin
                if (!chain[MaxThreads].found) begin
                  status <= ST_FULL;
                end else begin
                  cmd.create <= 1'b1;
                  cmd.ident  <= new_id;
                  cmd.prio   <= op_prio;
                  last_id    <= new_id;
                  result_id  <= new_id;
                end
              end
              K_SCHEDULE: begin
                if (!chain[MaxThreads].found ||
                    (cur_valid && cur_slot == chain[MaxThreads].slot)) begin
                  status <= ST_NOSWITCH;
                end else begin
                  status          <= ST_SWITCHED;
                  cur_slot        <= chain[MaxThreads].slot;
                  cur_valid       <= 1'b1;
                  cmd.reload      <= 1'b1;
                  result_id       <= chain[MaxThreads].ident;
                  result_priority <= chain[MaxThreads].prio;
                end
              end
              default: begin
                if (!chain[MaxThreads].found) begin
                  status <= ST_NOTFOUND;
                end else if (op == K_TERMINATE) begin
                  cmd.kill <= 1'b1;
                  if (cur_valid && cur_slot == chain[MaxThreads].slot)
                    cur_valid <= 1'b0;
                end else begin
                  cmd.susp_wr  <= 1'b1;
                  cmd.susp_val <= (op == K_SUSPEND);
                end
              end
            endcase
          end
        end
        S_FINISH: begin
          // scan commands already reported; tick and unused kinds report here
          state <= S_IDLE;
          if (!done) begin
            done            <= 1'b1;
            status          <= ST_DONE;
            result_id       <= '0;
            result_priority <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A result appears only while a command is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without command");
  // A switch always reports a current entry
  a_switch_cur: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_SWITCHED) |-> cur_valid) else $error("switch lost current");
  // While idle, the current slot holds a live entry
  a_cur_live: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && state == S_IDLE) |-> valid_vec[cur_slot]) else $error("stale current");
`endif

endmodule

// ===== hw/rtl/pts_cell.sv =====
// ---------------------------------------------------------------------------
// Scheduler table cell
// Holds one thread entry and folds it into the search word passing through.
// ---------------------------------------------------------------------------
module pts_cell import pts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [SlotW-1:0] my_slot,
  input  logic [2:0]       mode,      // command kind being searched
  input  logic [15:0]      key_id,
  input  pts_search_t      srch_in,
  input  logic             step,      // this cell's turn in the scan
  output pts_search_t      srch_out,
  input  pts_cmd_t         cmd,
  output logic             valid
);

  logic [15:0] ident;
  logic [7:0]  prio;
  logic [7:0]  countdown;
  logic        suspended;
  logic        hit;
  logic        better;

  // Match or election for this entry
  always_comb begin
    hit    = 1'b0;
    better = 1'b0;
    case (mode)
      K_CREATE:
        hit = !valid;
      K_SCHEDULE: begin
        hit = valid && !suspended && (prio != 8'd0) && (countdown == 8'd0);
        better = !srch_in.found || (prio > srch_in.prio) ||
                 ((prio == srch_in.prio) && (ident < srch_in.ident));
      end
      default:
        hit = valid && (ident == key_id);
    endcase
  end

  // Search word out: first hit wins, except election takes the better entry
  always_ff @(posedge clk) begin
    if (step) begin
      srch_out <= srch_in;
      if (hit && (mode == K_SCHEDULE ? better : !srch_in.found)) begin
        srch_out.found <= 1'b1;
        srch_out.slot  <= my_slot;
        srch_out.ident <= ident;
        srch_out.prio  <= prio;
      end
    end
  end

  // Entry state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (cmd.tick && valid && countdown != 8'd0) countdown <= countdown - 8'd1;
      if (cmd.wr_slot == my_slot) begin
        if (cmd.create) begin
          valid     <= 1'b1;
          ident     <= cmd.ident;
          prio      <= cmd.prio;
          countdown <= cmd.prio;
          suspended <= 1'b0;
        end
        if (cmd.kill) valid <= 1'b0;
        if (cmd.susp_wr) suspended <= cmd.susp_val;
        if (cmd.reload) countdown <= prio;
      end
    end
  end

endmodule
